FILE: rtl/lbdr_pkg.sv
// Shared types, codes and sizes for the lidar bird's-eye-view depth raster unit.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package lbdr_pkg;

	// storage size of the depth map
	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = $clog2(DEPTH);

	// stream payload widths
	localparam int S_TDATA_W = 96;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 3;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIX_PER_M   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN  = 3'd5;

	// request kinds
	typedef enum logic [1:0] {
		REQ_POINT = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [2:0] {
		RES_WRITTEN  = 3'd0,
		RES_FILTERED = 3'd1,
		RES_OFF_MAP  = 3'd2,
		RES_READ     = 3'd3,
		RES_CLEARED  = 3'd4
	} res_t;

	// configuration register file contents
	typedef struct packed {
		logic [10:0] map_width;
		logic [10:0] map_height;
		logic [15:0] pix_per_m;
		logic [22:0] min_range;
		logic [22:0] max_range;
		logic [23:0] depth_gain;
	} cfg_t;

	// controller states
	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CALC,
		S_MAP,
		S_ACCESS,
		S_WIPE,
		S_DONE
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic calc;
		logic map;
		logic access;
		logic wipe;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic wipe_last;
		logic out_stall;
	} stat_t;

endpackage

FILE: rtl/lidar_point_bev_depth_raster_unit.sv
// Top level of the lidar bird's-eye-view depth raster unit.
// Joins lbdr_regs, lbdr_ctrl and lbdr_datapath; depends on lbdr_pkg.
//
//   channel  direction  payload
//   s_*      in         request beat: tuser kind, tdata point and read pixel
//   m_*      out        result beat: tuser status, tdata pixel and value
//   cfg_*    in         register write, no read-back
//
// a point steps through calc, map, access and done to the next accept, a read
// through access and done, an unused code through done; the single memory port
// and the staged multiplies set these steps; a clear sweeps the map one byte a
// cycle, and after reset the same sweep runs before the first accept
// a result waits in the output register while the next beat is accepted;
// the block stalls only when a second result is ready and m_tready is low
`timescale 1ns / 1ps

module lidar_point_bev_depth_raster_unit
	import lbdr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// point_x[23:0], point_y[47:24], point_z[71:48], read_col[81:72],
	// read_row[91:82], zero fill
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// req_type[1:0]
	input  logic [S_TUSER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pixel_col[9:0], pixel_row[19:10], pixel_value[27:20], zero fill
	output logic [M_TDATA_W-1:0]  m_tdata,
	// status[2:0]
	output logic [M_TUSER_W-1:0]  m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t st;

	// register file
	lbdr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	lbdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_req   (req_t'(s_tuser)),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// arithmetic, memory and output register
	lbdr_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: rtl/lbdr_regs.sv
// Configuration register file of the depth raster unit.
// Depends on lbdr_pkg for the register indexes and the cfg_t layout.
`timescale 1ns / 1ps

module lbdr_regs
	import lbdr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_width  <= 11'd650;
			cfg_q.map_height <= 11'd650;
			cfg_q.pix_per_m  <= 16'd12800;
			cfg_q.min_range  <= 23'd51;
			cfg_q.max_range  <= 23'd7680;
			cfg_q.depth_gain <= 24'd2176;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAP_WIDTH:  cfg_q.map_width  <= cfg_data[10:0];
				REG_MAP_HEIGHT: cfg_q.map_height <= cfg_data[10:0];
				REG_PIX_PER_M:  cfg_q.pix_per_m  <= cfg_data[15:0];
				REG_MIN_RANGE:  cfg_q.min_range  <= cfg_data[22:0];
				REG_MAX_RANGE:  cfg_q.max_range  <= cfg_data[22:0];
				REG_DEPTH_GAIN: cfg_q.depth_gain <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/lbdr_ctrl.sv
// Sequencing state machine of the depth raster unit.
// Depends on lbdr_pkg for the state, request, command and status types.
`timescale 1ns / 1ps

module lbdr_ctrl
	import lbdr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  req_t  in_req,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.wipe = 1'b1;
				if (st.wipe_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_req)
						REQ_POINT: state_d = S_CALC;
						REQ_READ:  state_d = S_ACCESS;
						REQ_CLEAR: state_d = S_WIPE;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_MAP;
			end
			S_MAP: begin
				cmd.map = 1'b1;
				state_d = S_ACCESS;
			end
			S_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = S_DONE;
			end
			S_WIPE: begin
				cmd.wipe = 1'b1;
				if (st.wipe_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for room in the output register
				if (!st.out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

endmodule

FILE: rtl/lbdr_datapath.sv
// Datapath of the depth raster unit: input capture, filter and projection,
// depth map memory, wipe counter and output register. Depends on lbdr_pkg.
`timescale 1ns / 1ps

module lbdr_datapath
	import lbdr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  cmd_t                 cmd,
	output stat_t                st,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser
);

	localparam int W_EFF_W = COL_W + 1;
	localparam int H_EFF_W = ROW_W + 1;

	// captured request
	req_t               req_q;
	logic signed [23:0] x_q, y_q, z_q;
	logic [9:0]         rcol_q, rrow_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_t'(s_tuser);
			x_q    <= s_tdata[23:0];
			y_q    <= s_tdata[47:24];
			z_q    <= s_tdata[71:48];
			rcol_q <= s_tdata[81:72];
			rrow_q <= s_tdata[91:82];
		end
	end

	// range filter and the three products
	logic [24:0] ax_c, ay_c;
	logic        keep_c;

	always_comb begin
		ax_c = x_q[23] ? (~{x_q[23], x_q} + 25'd1) : {1'b0, x_q};
		ay_c = y_q[23] ? (~{y_q[23], y_q} + 25'd1) : {1'b0, y_q};
		keep_c = !z_q[23] && (z_q[22:0] != 23'd0)
			&& (z_q[22:0] >= cfg.min_range) && (z_q[22:0] <= cfg.max_range)
			&& (ax_c >= 25'(cfg.min_range)) && (ax_c <= 25'(cfg.max_range))
			&& (ay_c >= 25'(cfg.min_range)) && (ay_c <= 25'(cfg.max_range));
	end

	logic               keep_s2;
	logic signed [40:0] prod_x_s2, prod_y_s2;
	logic [46:0]        prod_z_s2;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			keep_s2   <= keep_c;
			prod_x_s2 <= x_q * $signed({1'b0, cfg.pix_per_m});
			prod_y_s2 <= y_q * $signed({1'b0, cfg.pix_per_m});
			prod_z_s2 <= z_q[22:0] * cfg.depth_gain;
		end
	end

	// ceiling of the x and y products, pixel position, map bounds and depth code
	logic [W_EFF_W-1:0] w_eff_c;
	logic [H_EFF_W-1:0] h_eff_c;
	logic signed [40:0] sx_c, sy_c;
	logic signed [26:0] col_c, row_c;
	logic               on_map_c;
	logic [7:0]         code_c;

	always_comb begin
		w_eff_c = (32'(cfg.map_width) > MAX_COLS) ? W_EFF_W'(MAX_COLS)
			: W_EFF_W'(cfg.map_width);
		h_eff_c = (32'(cfg.map_height) > MAX_ROWS) ? H_EFF_W'(MAX_ROWS)
			: H_EFF_W'(cfg.map_height);
		sx_c  = prod_x_s2 + 41'sd65535;
		sy_c  = prod_y_s2 + 41'sd65535;
		col_c = $signed(27'(w_eff_c[W_EFF_W-1:1])) - 27'($signed(sy_c[40:16]));
		row_c = $signed(27'(h_eff_c[H_EFF_W-1:1])) - 27'($signed(sx_c[40:16]));
		on_map_c = !col_c[26] && (col_c < $signed(27'(w_eff_c)))
			&& !row_c[26] && (row_c < $signed(27'(h_eff_c)));
		code_c = (|prod_z_s2[46:24]) ? 8'd255 : prod_z_s2[23:16];
	end

	res_t             pt_res_q;
	logic [COL_W-1:0] pt_col_q;
	logic [ROW_W-1:0] pt_row_q;
	logic [7:0]       pt_val_q;

	always_ff @(posedge clk) begin
		if (cmd.map) begin
			if (!keep_s2) begin
				pt_res_q <= RES_FILTERED;
				pt_col_q <= '0;
				pt_row_q <= '0;
				pt_val_q <= '0;
			end else if (!on_map_c) begin
				pt_res_q <= RES_OFF_MAP;
				pt_col_q <= '0;
				pt_row_q <= '0;
				pt_val_q <= '0;
			end else begin
				pt_res_q <= RES_WRITTEN;
				pt_col_q <= col_c[COL_W-1:0];
				pt_row_q <= row_c[ROW_W-1:0];
				pt_val_q <= 8'd255 - code_c;
			end
		end
	end

	// wipe counter, one entry a cycle
	logic [ADDR_W-1:0] clr_q;
	logic              clr_last;

	assign clr_last = (clr_q == ADDR_W'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.wipe) begin
			clr_q <= clr_last ? '0 : clr_q + 1'b1;
		end
	end

	// memory address and write select
	logic              in_store_c;
	logic [ADDR_W-1:0] pt_addr_c, rd_addr_c, addr_c;
	logic              we_c;
	logic [7:0]        wd_c;

	always_comb begin
		in_store_c = (32'(rcol_q) < MAX_COLS) && (32'(rrow_q) < MAX_ROWS);
		pt_addr_c  = ADDR_W'(pt_row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(pt_col_q);
		rd_addr_c  = ADDR_W'(COL_W'(rcol_q)) + ADDR_W'(ROW_W'(rrow_q)) * ADDR_W'(MAX_COLS);
		if (cmd.wipe) begin
			addr_c = clr_q;
			we_c   = 1'b1;
			wd_c   = 8'd0;
		end else begin
			addr_c = (req_q == REQ_POINT) ? pt_addr_c : rd_addr_c;
			we_c   = cmd.access && (req_q == REQ_POINT) && (pt_res_q == RES_WRITTEN);
			wd_c   = pt_val_q;
		end
	end

	// depth map, one port, registered read
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[addr_c] <= wd_c;
		end
		rd_q <= mem[addr_c];
	end

	// result select
	res_t       res_c;
	logic [9:0] res_col_c, res_row_c;
	logic [7:0] res_val_c;

	always_comb begin
		res_col_c = '0;
		res_row_c = '0;
		res_val_c = '0;
		case (req_q)
			REQ_POINT: begin
				res_c     = pt_res_q;
				res_col_c = 10'(pt_col_q);
				res_row_c = 10'(pt_row_q);
				res_val_c = pt_val_q;
			end
			REQ_READ: begin
				if (in_store_c) begin
					res_c     = RES_READ;
					res_col_c = rcol_q;
					res_row_c = rrow_q;
					res_val_c = rd_q;
				end else begin
					res_c = RES_OFF_MAP;
				end
			end
			REQ_CLEAR: res_c = RES_CLEARED;
			default:   res_c = RES_FILTERED;
		endcase
	end

	// output register
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic [M_TUSER_W-1:0] out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {4'd0, res_val_c, res_row_c, res_col_c};
			out_user_q <= res_c;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;
	assign m_tuser      = out_user_q;
	assign st.out_stall = out_valid_q && !m_tready;
	assign st.wipe_last = clr_last;

endmodule
